// ===== rtl/core/wcis_pkg.sv =====
package wcis_pkg;

  localparam int MAX_AP_COUNT_DEF = 255;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;
  localparam int SCORE_W     = 7;
  localparam int COEF_W      = 11;
  localparam int BASE_W      = 15;
  localparam int PROD_W      = 26;

  localparam logic [SCORE_W-1:0] SCORE_CAP = 7'd100;

  // P >= CAP * 1000 saturates; below that, P / 1000 == (P * RECIP) >> RECIP_SH
  localparam logic [PROD_W-1:0] PROD_SAT = 26'd100000;
  localparam int                QUOT_IN_W = 17;
  localparam logic [17:0]       RECIP     = 18'd134218;
  localparam int                RECIP_SH  = 27;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    BAND_24    = 2'd0,
    BAND_5     = 2'd1,
    BAND_6     = 2'd2,
    BAND_OTHER = 2'd3
  } band_t;

  localparam logic [2:0] WC_40  = 3'd2;
  localparam logic [2:0] WC_80  = 3'd3;
  localparam logic [2:0] WC_160 = 3'd4;

  // one classified record on its way to the accumulator
  typedef struct packed {
    logic               last;
    logic               same;
    logic [SCORE_W-1:0] same_add;
    logic [COEF_W-1:0]  coef;
    logic [6:0]         sig;
    logic [7:0]         mult;
  } wcis_entry_t;

  // signal weight tables indexed by clamped RSSI + 95
  localparam int SIG_LEN = 66;
  typedef logic [6:0] sig_tbl_t [SIG_LEN];

  function automatic sig_tbl_t mk_sig_tbl(int mul);
    sig_tbl_t t;
    int       w;
    for (int i = 0; i < SIG_LEN; i++) begin
      w    = (i * 100) / 65;
      t[i] = 7'((w * mul) / 100);
    end
    return t;
  endfunction

  localparam sig_tbl_t SIG_TBL  = mk_sig_tbl(100);
  localparam sig_tbl_t PEAK_TBL = mk_sig_tbl(30);
  localparam sig_tbl_t MEAN_TBL = mk_sig_tbl(15);

  // 5 GHz 20 MHz channels: pairs form 40 MHz, groups of four form 80 MHz
  localparam int CHAN5_LEN = 24;
  typedef logic [7:0] chan5_tbl_t [CHAN5_LEN];
  localparam chan5_tbl_t CHAN5 = '{
    8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd56,  8'd60,  8'd64,
    8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124, 8'd128,
    8'd132, 8'd136, 8'd140, 8'd144, 8'd149, 8'd153, 8'd157, 8'd161
  };
  localparam logic [4:0] CHAN5_NONE = 5'd24;

  function automatic logic [4:0] chan5_pos(input logic [7:0] ch);
    logic [4:0] pos;
    pos = CHAN5_NONE;
    for (int i = 0; i < CHAN5_LEN; i++) begin
      if (CHAN5[i] == ch) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/wcis_queue.sv =====
module wcis_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wcis_pkg::wcis_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output wcis_pkg::wcis_entry_t head,
  output logic                empty
);
  import wcis_pkg::*;

  wcis_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/core/wcis_front.sv =====
module wcis_front #(
  parameter int MAX_AP_COUNT = wcis_pkg::MAX_AP_COUNT_DEF
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wcis_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tlast,
  input  logic                          q_full,
  output logic                          push,
  output wcis_pkg::wcis_entry_t         push_data
);
  import wcis_pkg::*;

  localparam logic [15:0] AP_MAX = 16'(MAX_AP_COUNT);

  logic [1:0]        qband, oband;
  logic [7:0]        cand, obs, ap, n;
  logic [2:0]        wc;
  logic signed [7:0] peak, mean, peak_c, mean_c;
  logic [6:0]        peak_idx, mean_idx;
  logic [6:0]        sig, pk_part, mn_part, cnt;
  logic [7:0]        total;
  logic [7:0]        ch_dist;
  logic [4:0]        pos_c, pos_o;
  logic              both5, in40, in80, in160;
  logic              match, same;
  logic [COEF_W-1:0] coef_raw;

  assign qband = in_tdata[1:0];
  assign cand  = in_tdata[9:2];
  assign oband = in_tdata[11:10];
  assign obs   = in_tdata[19:12];
  assign wc    = in_tdata[22:20];
  assign ap    = in_tdata[30:23];
  assign peak  = in_tdata[38:31];
  assign mean  = in_tdata[46:39];

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    n = ({8'd0, ap} > AP_MAX) ? AP_MAX[7:0] : ap;

    peak_c = (peak < -8'sd95) ? -8'sd95 : ((peak > -8'sd30) ? -8'sd30 : peak);
    mean_c = (mean < -8'sd95) ? -8'sd95 : ((mean > -8'sd30) ? -8'sd30 : mean);
    peak_idx = 7'(peak_c + 8'sd95);
    mean_idx = 7'(mean_c + 8'sd95);

    // an RSSI of zero means no reading
    sig     = (peak == 8'sd0) ? 7'd0 : SIG_TBL[peak_idx];
    pk_part = (peak == 8'sd0) ? 7'd0 : PEAK_TBL[peak_idx];
    mn_part = (mean == 8'sd0) ? 7'd0 : MEAN_TBL[mean_idx];

    cnt   = (n >= 8'd5) ? 7'd55 : 7'(n[2:0] * 4'd11);
    total = 8'(cnt) + 8'(pk_part) + 8'(mn_part);

    ch_dist = (cand > obs) ? cand - obs : obs - cand;
    pos_c   = chan5_pos(cand);
    pos_o   = chan5_pos(obs);
    both5   = (pos_c != CHAN5_NONE) && (pos_o != CHAN5_NONE);
    in40    = both5 && (pos_c[4:1] == pos_o[4:1]);
    in80    = both5 && (pos_c[4:2] == pos_o[4:2]);
    in160   = ((cand >= 8'd36) && (cand <= 8'd64) && (obs >= 8'd36) && (obs <= 8'd64)) ||
              ((cand >= 8'd100) && (cand <= 8'd128) && (obs >= 8'd100) && (obs <= 8'd128));

    // overlap weight scaled so that every case divides by 1000
    coef_raw = '0;
    case (oband)
      BAND_24: begin
        if (wc >= WC_40) begin
          if (ch_dist < 8'd9) coef_raw = 11'd1200 - 11'(ch_dist[3:0]) * 11'd120;
        end else begin
          if (ch_dist < 8'd5) coef_raw = 11'd1000 - 11'(ch_dist[2:0]) * 11'd200;
        end
      end
      BAND_5: begin
        if (wc < WC_40) begin
          if (ch_dist < 8'd4) coef_raw = 11'd1000 - 11'(ch_dist[1:0]) * 11'd250;
        end else if (wc >= WC_160) begin
          if (in160) coef_raw = 11'd1000;
        end else if (wc == WC_80) begin
          if (in80) coef_raw = 11'd900;
        end else begin
          if (in40) coef_raw = 11'd750;
        end
      end
      BAND_6: begin
        if (ch_dist < 8'd4) coef_raw = 11'd1000 - 11'(ch_dist[1:0]) * 11'd250;
      end
      default: coef_raw = '0;
    endcase

    match = (qband == oband);
    same  = match && (obs == cand);

    push_data.last     = in_tlast;
    push_data.same     = same;
    push_data.same_add = (n == 8'd0) ? 7'd0 :
                         ((total > 8'(SCORE_CAP)) ? SCORE_CAP : total[6:0]);
    push_data.coef     = match ? coef_raw : '0;
    push_data.sig      = sig;
    push_data.mult     = (n == 8'd0) ? 8'd1 : n;
  end

endmodule

// ===== rtl/core/wcis_back.sv =====
module wcis_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  wcis_pkg::wcis_entry_t           q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wcis_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wcis_pkg::*;

  logic                  en;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_last_r, s1_same_r;
  logic [SCORE_W-1:0]    s1_same_add_r;
  logic [COEF_W-1:0]     s1_coef_r;
  logic [BASE_W-1:0]     s1_base_r;

  logic                  s2_valid_r;
  logic                  s2_last_r, s2_same_r;
  logic [SCORE_W-1:0]    s2_same_add_r;
  logic [PROD_W-1:0]     s2_prod_r;

  logic                  s3_valid_r;
  logic                  s3_last_r;
  logic [SCORE_W-1:0]    s3_add_r, s3_add_nxt;
  logic [QUOT_IN_W+17:0] quot_full;

  logic [SCORE_W-1:0]    acc_r, acc_nxt;
  logic [SCORE_W:0]      sum;
  logic [SCORE_W-1:0]    sum_sat;
  logic                  out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]    score_r;

  // the whole back end moves only when the output register can take a result
  assign en           = !out_valid_r || out_tready;
  assign q_pop        = en && !q_empty;
  assign s1_valid_nxt = !q_empty;

  always_comb begin
    quot_full  = s2_prod_r[QUOT_IN_W-1:0] * RECIP;
    s3_add_nxt = s2_same_r ? s2_same_add_r :
                 ((s2_prod_r >= PROD_SAT) ? SCORE_CAP : quot_full[RECIP_SH+6:RECIP_SH]);

    sum     = {1'b0, acc_r} + {1'b0, s3_add_r};
    sum_sat = (sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[SCORE_W-1:0];

    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = s3_valid_r && s3_last_r;
      if (s3_valid_r) acc_nxt = s3_last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s1_valid_r <= s1_valid_nxt;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
      end
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r     <= q_head.last;
      s1_same_r     <= q_head.same;
      s1_same_add_r <= q_head.same_add;
      s1_coef_r     <= q_head.coef;
      s1_base_r     <= BASE_W'(q_head.sig * q_head.mult);

      s2_last_r     <= s1_last_r;
      s2_same_r     <= s1_same_r;
      s2_same_add_r <= s1_same_add_r;
      s2_prod_r     <= PROD_W'(s1_coef_r * s1_base_r);

      s3_last_r     <= s2_last_r;
      s3_add_r      <= s3_add_nxt;

      if (s3_valid_r && s3_last_r) score_r <= sum_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, score_r};

endmodule

// ===== rtl/core/wifi_channel_interference_score_top.sv =====
// Congestion score for one candidate Wi-Fi channel.
//
// Input stream: one observed-channel record per transaction; tlast marks the
// final record of a run. Records of another band add nothing, a record on the
// candidate channel adds same-channel congestion, any other record adds a
// width-aware overlap penalty. The running score saturates at 100.
// Output stream: one transaction per run, carrying the score (0..100), sent
// after the record with tlast is accepted; records without tlast send nothing.
//
// Throughput: one record per cycle while the receiver does not stall. A score
// passes the queue write at the accepting edge, then multiply, scale multiply,
// divide by reciprocal, and accumulate into the output register.
// A 4-entry queue splits the classify front from the arithmetic back end.
// When the receiver stalls, the back end holds, the queue fills, and in_tready
// drops once it is full; nothing is lost. Reset empties the queue, the
// pipeline and the running score, and leaves in_tready high.
module wifi_channel_interference_score_top #(
  parameter int MAX_AP_COUNT = wcis_pkg::MAX_AP_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // query_band[1:0], candidate_channel[9:2], observed_band[11:10],
  // observed_channel[19:12], width_code[22:20], ap_count[30:23],
  // peak_rssi[38:31], mean_rssi[46:39], zero fill[47]
  input  logic [wcis_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // score[6:0], zero fill[7]
  output logic [wcis_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wcis_pkg::*;

  wcis_entry_t push_data, q_head;
  logic        push, q_full, q_pop, q_empty;

  wcis_front #(
    .MAX_AP_COUNT(MAX_AP_COUNT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  wcis_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  wcis_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/core/wcis_checker.sv =====
module wcis_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wcis_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wcis_pkg::*;

  // score never exceeds the cap and the fill bit stays clear
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= OUT_TDATA_W'(SCORE_CAP)))
    else $error("score above cap");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed while stalled");

  // reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result visible after reset");

  // reset empties the queue, so the input side is ready at once
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind wifi_channel_interference_score_top wcis_checker u_wcis_checker (.*);

// ===== bench/tb_wifi_channel_interference_score_top.sv =====
module tb_wifi_channel_interference_score_top;
  import wcis_pkg::*;

  localparam int SCORE_LIMIT = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_RECORDS = 750;
  localparam int HOLD_OFF_CYCLES = 300;

  // one observed-channel record as the sender sees it
  typedef struct packed {
    logic       last;
    logic [7:0] mean_rssi;
    logic [7:0] peak_rssi;
    logic [7:0] ap_count;
    logic [2:0] width_code;
    logic [7:0] obs_chan;
    band_t      obs_band;
    logic [7:0] cand_chan;
    band_t      query_band;
  } rec_t;

  class score_tracker;
    int running;
    int pending_scores[$];
    int errors;
    int n_records;
    int n_scores;
    int n_capped;
    int n_zero;

    function int signal_weight(logic [7:0] raw);
      int r;
      r = $signed(raw);
      if (r == 0) return 0;
      if (r < -95) r = -95;
      if (r > -30) r = -30;
      return (r + 95) * 100 / 65;
    endfunction

    // position in the 5 GHz 20 MHz channel list, 24 when not listed
    function int chan5_slot(int ch);
      if (ch >= 36 && ch <= 64 && ch % 4 == 0) return (ch - 36) / 4;
      if (ch >= 100 && ch <= 144 && ch % 4 == 0) return 8 + (ch - 100) / 4;
      if (ch >= 149 && ch <= 161 && ch % 4 == 1) return 20 + (ch - 149) / 4;
      return 24;
    endfunction

    function longint record_increment(rec_t r);
      int     cand, obs, n, wc, ch_dist, a, b, strength;
      longint base;
      cand = r.cand_chan;
      obs  = r.obs_chan;
      n    = r.ap_count;
      wc   = r.width_code;
      if (r.query_band != r.obs_band) return 0;
      if (obs == cand) begin
        if (n == 0) return 0;
        a = (n * 11 > 55) ? 55 : n * 11;
        a += signal_weight(r.peak_rssi) * 30 / 100 + signal_weight(r.mean_rssi) * 15 / 100;
        return (a > SCORE_LIMIT) ? SCORE_LIMIT : a;
      end
      ch_dist = (cand > obs) ? cand - obs : obs - cand;
      base = longint'(signal_weight(r.peak_rssi)) * ((n == 0) ? 1 : n);
      if (r.obs_band == BAND_24) begin
        if (wc >= WC_40) return (ch_dist >= 9) ? 0 : (100 - ch_dist * 10) * base * 12 / 1000;
        return (ch_dist >= 5) ? 0 : (100 - ch_dist * 20) * base / 100;
      end
      if (r.obs_band == BAND_6 || (r.obs_band == BAND_5 && wc < WC_40)) begin
        return (ch_dist >= 4) ? 0 : (100 - ch_dist * 25) * base / 100;
      end
      if (r.obs_band != BAND_5) return 0;
      a = chan5_slot(cand);
      b = chan5_slot(obs);
      strength = 0;
      if (wc >= WC_160) begin
        if ((cand >= 36 && cand <= 64 && obs >= 36 && obs <= 64) ||
            (cand >= 100 && cand <= 128 && obs >= 100 && obs <= 128)) strength = 100;
      end else if (wc == WC_80) begin
        if (a < 24 && b < 24 && a / 4 == b / 4) strength = 90;
      end else if (a < 24 && b < 24 && a / 2 == b / 2) begin
        strength = 75;
      end
      return strength * base / 100;
    endfunction

    function void note_record(rec_t r);
      longint sum;
      sum = record_increment(r) + running;
      running = (sum > SCORE_LIMIT) ? SCORE_LIMIT : int'(sum);
      n_records++;
      if (r.last) begin
        pending_scores = {pending_scores, running};
        if (running == SCORE_LIMIT) n_capped++;
        if (running == 0) n_zero++;
        running = 0;
      end
    endfunction

    function void check_score(logic [6:0] got);
      int want;
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected score transaction, expected none, got %0d", $time, got);
        return;
      end
      want = pending_scores.pop_front();
      n_scores++;
      if (got != want) begin
        errors++;
        $display("%0t: score mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  score_tracker tracker;
  rec_t         stim[$];
  int           cycle_count = 0;

  wifi_channel_interference_score_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int chan5_at(int slot);
    if (slot < 8) return 36 + 4 * slot;
    if (slot < 20) return 100 + 4 * (slot - 8);
    return 149 + 4 * (slot - 20);
  endfunction

  function automatic logic [7:0] random_rssi();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'($urandom_range(0, 255));
    return 8'(int'($urandom_range(0, 80)) - 100);
  endfunction

  function automatic void add_record(int qb, int cand, int ob, int obs, int wc, int ap,
                                     int pk, int mn, bit last);
    rec_t r;
    r.query_band = band_t'(qb);
    r.cand_chan  = 8'(cand);
    r.obs_band   = band_t'(ob);
    r.obs_chan   = 8'(obs);
    r.width_code = 3'(wc);
    r.ap_count   = 8'(ap);
    r.peak_rssi  = 8'(pk);
    r.mean_rssi  = 8'(mn);
    r.last       = last;
    stim = {stim, r};
  endfunction

  task automatic send_records();
    int k, burst, gap;
    k = 0;
    while (k < stim.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      while (burst > 0 && k < stim.size()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, stim[k].mean_rssi, stim[k].peak_rssi, stim[k].ap_count,
                      stim[k].width_code, stim[k].obs_chan, stim[k].obs_band,
                      stim[k].cand_chan, stim[k].query_band};
        in_tlast  <= stim[k].last;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        tracker.note_record(stim[k]);
        k++;
        burst--;
      end
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // score transactions
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_score(out_tdata[6:0]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: stall patterns in segments, plus one long hold-off to back up the queue
  initial begin : receiver
    int mode, span, phase;
    bit held;
    out_tready = 1'b0;
    held  = 1'b0;
    phase = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        phase++;
        if (!held && tracker.n_scores >= 60) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= (phase % 3 != 0);
          endcase
        end
      end
    end
  end

  initial begin
    int added, run_len, qb, cand, obs, k, pick;
    rec_t r;
    tracker   = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;

    add_record(0, 6, 1, 6, 1, 5, -40, -50, 1);       // other band, skipped
    add_record(0, 6, 0, 6, 1, 255, -30, -30, 1);     // same channel, full weight
    add_record(0, 6, 0, 6, 1, 0, -40, -40, 1);       // no APs on same channel
    add_record(0, 6, 0, 7, 1, 0, -50, 0, 1);         // overlap, zero APs, mean absent
    add_record(0, 1, 0, 9, 2, 3, -60, -70, 1);
    add_record(0, 1, 0, 10, 4, 3, -60, -70, 1);
    add_record(0, 1, 0, 5, 1, 2, -45, -45, 1);
    add_record(0, 1, 0, 6, 0, 2, -45, -45, 1);
    add_record(1, 36, 1, 40, 2, 4, -55, -60, 1);     // 40 MHz pair
    add_record(1, 36, 1, 48, 3, 4, -55, -60, 1);     // 80 MHz block
    add_record(1, 36, 1, 64, 4, 4, -55, -60, 1);     // 160 MHz block
    add_record(1, 36, 1, 100, 7, 4, -55, -60, 1);    // width code above 160
    add_record(1, 149, 1, 161, 3, 9, -35, -35, 1);
    add_record(1, 149, 1, 161, 5, 9, -35, -35, 1);
    add_record(1, 36, 1, 38, 1, 4, -55, 0, 1);
    add_record(2, 5, 2, 8, 4, 10, -40, -40, 1);
    add_record(3, 5, 3, 5, 1, 4, -50, -50, 1);       // other band, same channel counts
    add_record(3, 5, 3, 6, 1, 4, -50, -50, 1);
    add_record(0, 6, 0, 6, 1, 3, 100, -128, 1);      // positive and below-floor RSSI
    add_record(0, 6, 0, 7, 1, 255, -30, -30, 0);     // huge overlap product, saturates
    add_record(0, 6, 0, 6, 1, 255, -30, -30, 0);
    add_record(0, 6, 2, 6, 1, 255, -30, -30, 1);
    add_record(0, 255, 0, 0, 7, 255, 127, -1, 1);
    add_record(0, 0, 0, 255, 0, 128, -128, -128, 1);

    // random runs: mostly well-formed runs around a candidate, some noise
    added = 0;
    while (added < RANDOM_RECORDS) begin
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      qb = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      case (qb)
        0: cand = $urandom_range(1, 14);
        1: cand = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 170)
                                              : chan5_at($urandom_range(0, 23));
        2: cand = $urandom_range(0, 58) * 4 + 1;
        default: cand = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 15) == 0) cand = $urandom_range(0, 255);
      for (k = 0; k < run_len; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 5) obs = cand;
        else if (pick < 14) obs = cand + int'($urandom_range(0, 20)) - 10;
        else if (pick < 17) obs = chan5_at($urandom_range(0, 23));
        else obs = $urandom_range(0, 255);
        if (obs < 0) obs = 0;
        if (obs > 255) obs = 255;
        r.query_band = band_t'(qb);
        r.cand_chan  = 8'(cand);
        r.obs_band   = ($urandom_range(0, 4) == 0) ? band_t'($urandom_range(0, 3)) : band_t'(qb);
        r.obs_chan   = 8'(obs);
        r.width_code = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
        r.ap_count   = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 12));
        r.peak_rssi  = random_rssi();
        r.mean_rssi  = random_rssi();
        if ($urandom_range(0, 15) == 0) r = rec_t'(48'({$urandom, $urandom}));
        r.last = (k == run_len - 1);
        stim = {stim, r};
      end
      added += run_len;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_records();
    while (tracker.pending_scores.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d records sent, %0d scores checked (%0d saturated, %0d zero)",
             tracker.n_records, tracker.n_scores, tracker.n_capped, tracker.n_zero);
    $display("covered band, width, distance and RSSI corners and random runs under stalls");
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
